>>> src/wad_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and control types of the windowed average block.
package wad_pkg;

    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int WLEN_W     = 6;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(32);
    localparam logic [THR_W-1:0]  THR_RESET  = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_ACCUM,
        S_BAND,
        S_START,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic accum;
        logic band;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } status_t;

endpackage

>>> src/wad_div.sv
`timescale 1ns / 1ps
// Two-lane restoring divider: signed sums by the fill count, one quotient bit a cycle.
module wad_div
    import wad_pkg::*;
#(
    parameter int SUM_W       = 21,
    parameter int CNT_W       = 6,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SUM_W-1:0]       dividend_x,
    input  logic signed [SUM_W-1:0]       dividend_y,
    input  logic        [CNT_W-1:0]       divisor,
    output logic                          busy,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] quot_x,
    output logic signed [SAMPLE_BITS-1:0] quot_y
);

    localparam int ITER_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [CNT_W-1:0]  dvs_reg,  dvs_next;

    logic signed [SUM_W-1:0] dividend [2];
    logic [SUM_W-1:0]        mag_reg  [2];
    logic [SUM_W-1:0]        mag_next [2];
    logic [CNT_W-1:0]        rem_reg  [2];
    logic [CNT_W-1:0]        rem_next [2];
    logic                    neg_reg  [2];
    logic                    neg_next [2];
    logic [SUM_W-1:0]        signed_q [2];

    assign dividend[0] = dividend_x;
    assign dividend[1] = dividend_y;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = ITER_W'(SUM_W);
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            iter_next = iter_reg - ITER_W'(1);
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [CNT_W:0] trial;

        always_comb
        begin
            trial       = {rem_reg[l], mag_reg[l][SUM_W-1]};
            mag_next[l] = mag_reg[l];
            rem_next[l] = rem_reg[l];
            neg_next[l] = neg_reg[l];
            if (start)
            begin
                neg_next[l] = dividend[l][SUM_W-1];
                mag_next[l] = dividend[l][SUM_W-1] ? (~dividend[l] + SUM_W'(1))
                                                   : dividend[l];
                rem_next[l] = '0;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next[l] = CNT_W'(trial - {1'b0, dvs_reg});
                    mag_next[l] = {mag_reg[l][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[CNT_W-1:0];
                    mag_next[l] = {mag_reg[l][SUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            mag_reg[l] <= mag_next[l];
            rem_reg[l] <= rem_next[l];
            neg_reg[l] <= neg_next[l];
        end

        // truncate toward zero: divide the magnitude, then restore the sign
        assign signed_q[l] = neg_reg[l] ? (~mag_reg[l] + SUM_W'(1)) : mag_reg[l];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign quot_x = signed_q[0][SAMPLE_BITS-1:0];
    assign quot_y = signed_q[1][SAMPLE_BITS-1:0];

endmodule

>>> src/wad_datapath.sv
`timescale 1ns / 1ps
// Datapath: sample window memory, running and held sums, deadband test, divider, output item.
module wad_datapath
    import wad_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output status_t                       status,
    input  logic signed [SAMPLE_BITS-1:0] sample_x,
    input  logic signed [SAMPLE_BITS-1:0] sample_y,
    input  logic        [WLEN_W-1:0]      window_len,
    input  logic        [THR_W-1:0]       threshold,
    output logic signed [SAMPLE_BITS-1:0] avg_x,
    output logic signed [SAMPLE_BITS-1:0] avg_y,
    output logic                          updated
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + PTR_W;
    localparam int LEN_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    localparam int PROD_W = THR_W + CNT_W;
    localparam int CMP_W  = (PROD_W > SUM_W + 1) ? PROD_W : SUM_W + 1;
    localparam int ENT_W  = 2 * SAMPLE_BITS;

    // window memory: x in the upper half, y in the lower half
    logic [ENT_W-1:0] win_mem [MAX_WINDOW];
    logic [ENT_W-1:0] rd_reg;

    logic signed [SAMPLE_BITS-1:0] sx_reg, sy_reg;
    logic [PTR_W-1:0]        slot_reg, slot_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic signed [SUM_W-1:0] run_x_reg, run_x_next, run_y_reg, run_y_next;
    logic signed [SUM_W-1:0] held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic                    upd_reg, upd_next;
    logic signed [SAMPLE_BITS-1:0] avg_x_reg, avg_y_reg;
    logic                    updated_reg;

    logic [LEN_W-1:0]        len_raw, len_eff;
    logic                    drop;
    logic [CNT_W:0]          old_diff;
    logic [PTR_W-1:0]        old_addr;
    logic signed [SAMPLE_BITS-1:0] old_x, old_y;
    logic signed [SUM_W-1:0] sub_x, sub_y;
    logic signed [SUM_W:0]   diff_x, diff_y;
    logic [SUM_W:0]          mag_x, mag_y;
    logic [PROD_W-1:0]       band;
    logic                    out_x, out_y;
    logic signed [SAMPLE_BITS-1:0] quot_x, quot_y;

    // clamp window length to 1..MAX_WINDOW
    always_comb
    begin
        len_raw = LEN_W'(window_len);
        priority if (len_raw == '0)
            len_eff = LEN_W'(1);
        else if (len_raw > LEN_W'(MAX_WINDOW))
            len_eff = LEN_W'(MAX_WINDOW);
        else
            len_eff = len_raw;
    end

    assign drop = LEN_W'(fill_reg) >= len_eff;

    // oldest slot: write slot minus fill count, wrapped into the window
    always_comb
    begin
        old_diff = (CNT_W + 1)'(slot_reg) - (CNT_W + 1)'(fill_reg);
        if (old_diff[CNT_W])
            old_diff = old_diff + (CNT_W + 1)'(MAX_WINDOW);
        old_addr = old_diff[PTR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accum)
            win_mem[slot_reg] <= {sx_reg, sy_reg};
        if (cmd.fetch)
            rd_reg <= win_mem[old_addr];
    end

    assign old_x = rd_reg[ENT_W-1:SAMPLE_BITS];
    assign old_y = rd_reg[SAMPLE_BITS-1:0];
    assign sub_x = drop ? SUM_W'(old_x) : '0;
    assign sub_y = drop ? SUM_W'(old_y) : '0;

    assign diff_x = (SUM_W + 1)'(held_x_reg) - (SUM_W + 1)'(run_x_reg);
    assign diff_y = (SUM_W + 1)'(held_y_reg) - (SUM_W + 1)'(run_y_reg);
    assign mag_x  = diff_x[SUM_W] ? -diff_x : diff_x;
    assign mag_y  = diff_y[SUM_W] ? -diff_y : diff_y;
    assign band   = PROD_W'(threshold) * PROD_W'(fill_reg);
    assign out_x  = CMP_W'(mag_x) > CMP_W'(band);
    assign out_y  = CMP_W'(mag_y) > CMP_W'(band);

    always_comb
    begin
        slot_next   = slot_reg;
        fill_next   = fill_reg;
        run_x_next  = run_x_reg;
        run_y_next  = run_y_reg;
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        upd_next    = upd_reg;
        if (cmd.accum)
        begin
            // drop the oldest sample once full, else grow the window
            if (!drop)
                fill_next = fill_reg + CNT_W'(1);
            slot_next  = (slot_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : slot_reg + PTR_W'(1);
            run_x_next = run_x_reg - sub_x + SUM_W'(sx_reg);
            run_y_next = run_y_reg - sub_y + SUM_W'(sy_reg);
        end
        if (cmd.band)
        begin
            if (out_x)
                held_x_next = run_x_reg;
            if (out_y)
                held_y_next = run_y_reg;
            upd_next = out_x | out_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            fill_reg   <= '0;
            run_x_reg  <= '0;
            run_y_reg  <= '0;
            held_x_reg <= '0;
            held_y_reg <= '0;
        end
        else
        begin
            slot_reg   <= slot_next;
            fill_reg   <= fill_next;
            run_x_reg  <= run_x_next;
            run_y_reg  <= run_y_next;
            held_x_reg <= held_x_next;
            held_y_reg <= held_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upd_reg <= upd_next;
        if (cmd.capture)
        begin
            sx_reg <= sample_x;
            sy_reg <= sample_y;
        end
        if (cmd.out_load)
        begin
            avg_x_reg   <= quot_x;
            avg_y_reg   <= quot_y;
            updated_reg <= upd_reg;
        end
    end

    wad_div #(
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.div_start),
        .dividend_x (held_x_reg),
        .dividend_y (held_y_reg),
        .divisor    (fill_reg),
        .busy       (status.div_busy),
        .done       (status.div_done),
        .quot_x     (quot_x),
        .quot_y     (quot_y)
    );

    assign avg_x   = avg_x_reg;
    assign avg_y   = avg_y_reg;
    assign updated = updated_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_WINDOW))
        else $error("fill count above window depth");

    a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum && !drop |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("fill count did not grow on a non-full window");

    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum && drop |=> fill_reg == $past(fill_reg))
        else $error("fill count moved on a full window");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= PTR_W'(MAX_WINDOW - 1))
        else $error("write slot outside window");
`endif

endmodule

>>> src/wad_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one item through fetch, accumulate, deadband, divide and output.
module wad_ctrl
    import wad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = S_BAND;
            end
            S_BAND:
            begin
                cmd.band   = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output item overwritten while stalled");

    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && status.div_done |=> state_reg == S_OUT)
        else $error("divider result not taken");
`endif

endmodule

>>> src/windowed_average_deadband.sv
`timescale 1ns / 1ps
// Top level of the two-axis windowed average with deadband on the held output.
//
// Input channel: sample_x, sample_y with in_valid; the block raises in_stall
// while it works on an item. An item is taken when in_valid is high and
// in_stall low. Output channel: avg_x, avg_y, updated with out_valid; the
// receiver holds out_stall high to keep the item in the output register.
// Configuration: cfg_valid with cfg_index 0 (window length, cfg_data[5:0])
// or 1 (threshold, cfg_data[15:0]); cfg_ready is always high. Write only
// while no item is in flight.
// Each item passes through fetch, accumulate, deadband test and divider
// start, then the bit-serial divider (one quotient bit per cycle) works on
// sums of SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) bits before the output load.
// One item is in flight at a time and the next is taken in the cycle after
// the output load. If the receiver stalls, the finished item waits in the
// output register, the next item is still accepted and processed, and it
// waits before its own load until the register frees.
// Reset clears the window fill, write slot, running and held sums, sets the
// window length to 32 and the threshold to 0, and empties the output.
module windowed_average_deadband
    import wad_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_x,
    input  logic signed [SAMPLE_BITS-1:0] sample_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] avg_x,
    output logic signed [SAMPLE_BITS-1:0] avg_y,
    output logic                          updated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    logic [WLEN_W-1:0] wlen_reg;
    logic [THR_W-1:0]  thr_reg;
    cmd_t              cmd;
    status_t           status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_RESET;
            thr_reg  <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LEN: wlen_reg <= cfg_data[WLEN_W-1:0];
                CFG_THRESHOLD:  thr_reg  <= cfg_data[THR_W-1:0];
            endcase
        end
    end

    wad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    wad_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample_x   (sample_x),
        .sample_y   (sample_y),
        .window_len (wlen_reg),
        .threshold  (thr_reg),
        .avg_x      (avg_x),
        .avg_y      (avg_y),
        .updated    (updated)
    );

endmodule

>>> tb/windowed_average_deadband_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the two-axis windowed average with deadband.
module windowed_average_deadband_tb;
    import wad_pkg::*;

    localparam int SW         = SAMPLE_BITS_DEF;
    localparam int MAXW       = MAX_WINDOW_DEF;
    localparam int QUIET_MAX  = 3000;
    localparam int TAIL_WAIT  = 40;
    localparam int PHASE_ITEMS = 80;

    typedef struct {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
    } sample_pair_t;

    typedef struct {
        logic signed [SW-1:0] avg_x;
        logic signed [SW-1:0] avg_y;
        logic                 updated;
    } avg_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic signed [SW-1:0]   sample_x = '0;
    logic signed [SW-1:0]   sample_y = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [SW-1:0]   avg_x;
    logic signed [SW-1:0]   avg_y;
    logic                   updated;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    sample_pair_t pending_pairs[$];
    avg_result_t  expected_avgs[$];

    // predicted block state
    logic [WLEN_W-1:0] cur_wlen = WLEN_RESET;
    logic [THR_W-1:0]  cur_thr = THR_RESET;
    longint            win_x[MAXW];
    longint            win_y[MAXW];
    int                slot = 0;
    int                fill = 0;
    longint            run_x = 0;
    longint            run_y = 0;
    longint            held_x = 0;
    longint            held_y = 0;

    int           errors = 0;
    int           quiet_cycles = 0;
    int           gap_left = 0;
    int           stall_left = 0;
    bit           idle_on = 1'b1;
    int           drift_x = 0;
    int           drift_y = 0;
    avg_result_t  drv_res;
    sample_pair_t drv_pair;
    avg_result_t  want;

    windowed_average_deadband DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_x  (sample_x),
        .sample_y  (sample_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .avg_x     (avg_x),
        .avg_y     (avg_y),
        .updated   (updated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the window by one sample pair and work out the held averages.
    task automatic predict_average(input logic signed [SW-1:0] sx,
                                   input logic signed [SW-1:0] sy,
                                   output avg_result_t res);
        int     len;
        int     oldest;
        longint band;
        longint dx;
        longint dy;
        longint qx;
        longint qy;
        len = int'(cur_wlen);
        if (len == 0)
            len = 1;
        if (len > MAXW)
            len = MAXW;
        if (fill >= len)
        begin
            oldest = (slot + MAXW - fill) % MAXW;
            run_x -= win_x[oldest];
            run_y -= win_y[oldest];
        end
        else
        begin
            fill++;
        end
        win_x[slot] = sx;
        win_y[slot] = sy;
        slot = (slot + 1) % MAXW;
        run_x += sx;
        run_y += sy;
        band = longint'(cur_thr) * longint'(fill);
        res.updated = 1'b0;
        dx = held_x - run_x;
        if (dx < 0)
            dx = -dx;
        if (dx > band)
        begin
            held_x = run_x;
            res.updated = 1'b1;
        end
        dy = held_y - run_y;
        if (dy < 0)
            dy = -dy;
        if (dy > band)
        begin
            held_y = run_y;
            res.updated = 1'b1;
        end
        qx = held_x / longint'(fill);
        qy = held_y / longint'(fill);
        res.avg_x = qx[SW-1:0];
        res.avg_y = qy[SW-1:0];
    endtask

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [SW-1:0] clamp_sample(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[SW-1:0];
    endfunction

    // Mix of rail values, values near a slow drift (exercises the deadband) and noise.
    function automatic logic signed [SW-1:0] pick_sample(input int center);
        int r;
        logic [31:0] raw;
        r = $urandom_range(0, 19);
        raw = $urandom;
        if (r == 0)
            return 16'sh7fff;
        if (r == 1)
            return 16'sh8000;
        if (r < 11)
            return clamp_sample(center + $urandom_range(0, 80) - 40);
        return raw[SW-1:0];
    endfunction

    task automatic push_pair(input int x, input int y);
        sample_pair_t p;
        p.x = x[SW-1:0];
        p.y = y[SW-1:0];
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_WINDOW_LEN)
            cur_wlen = data[WLEN_W-1:0];
        else
            cur_thr = data[THR_W-1:0];
    endtask

    task automatic apply_setting(input logic [WLEN_W-1:0] wlen, input logic [THR_W-1:0] thr);
        logic [CFG_DATA_W-1:0] word;
        // upper bits of the length word are don't-care; toggle them anyway
        word = CFG_DATA_W'($urandom);
        word[WLEN_W-1:0] = wlen;
        write_reg(CFG_WINDOW_LEN, word);
        write_reg(CFG_THRESHOLD, thr);
    endtask

    // sample at the falling edge so the driver's and monitor's updates have settled
    task automatic drain();
        do
            @(negedge clk);
        while (pending_pairs.size() != 0 || expected_avgs.size() != 0 || in_valid);
    endtask

    // Input driver: hold a stalled item, otherwise idle or present the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample_x <= '0;
            sample_y <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_average(sample_x, sample_y, drv_res);
                expected_avgs.insert(expected_avgs.size(), drv_res);
            end
            if (in_valid && in_stall)
            begin
                // hold the item
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_pairs.size() > 0)
            begin
                drv_pair = pending_pairs[0];
                pending_pairs.delete(0);
                in_valid <= 1'b1;
                sample_x <= drv_pair.x;
                sample_y <= drv_pair.y;
                gap_left <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: check each taken item against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_avgs.size() == 0)
                begin
                    $error("unexpected item: avg_x %0d avg_y %0d updated %0d",
                           avg_x, avg_y, updated);
                    errors++;
                end
                else
                begin
                    want = expected_avgs[0];
                    expected_avgs.delete(0);
                    if (avg_x !== want.avg_x)
                    begin
                        $error("avg_x mismatch: expected %0d, actual %0d", want.avg_x, avg_x);
                        errors++;
                    end
                    if (avg_y !== want.avg_y)
                    begin
                        $error("avg_y mismatch: expected %0d, actual %0d", want.avg_y, avg_y);
                        errors++;
                    end
                    if (updated !== want.updated)
                    begin
                        $error("updated mismatch: expected %0d, actual %0d",
                               want.updated, updated);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= pick_stall();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_MAX);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int p;
        int k;
        logic [WLEN_W-1:0] wlen;
        logic [THR_W-1:0]  thr;
        logic [31:0]       raw;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero length right after reset acts as a window of one
        apply_setting(6'd0, 16'd0);
        push_pair(32767, -32768);
        push_pair(-32768, 32767);
        push_pair(0, -1);
        drain();

        // grow to four, widest deadband, rail samples
        apply_setting(6'd4, 16'hffff);
        push_pair(32767, 32767);
        push_pair(32767, 32767);
        push_pair(-32768, -32768);
        push_pair(-32768, -32768);
        push_pair(1, -1);
        drain();

        // length above the maximum saturates
        apply_setting(6'd63, 16'd1);
        push_pair(-32768, -32768);
        push_pair(32767, 0);
        push_pair(0, 32767);
        push_pair(-1, -1);
        push_pair(100, -100);
        drain();

        // lower the length while the window holds more samples
        apply_setting(6'd2, 16'd0);
        push_pair(5, 5);
        push_pair(-5, -5);
        push_pair(7, -7);
        drain();

        for (p = 0; p < 8; p++)
        begin
            raw = $urandom;
            case (p)
                0: begin wlen = 6'd12; thr = 16'd0; end
                1: begin wlen = 6'd20; thr = 16'd50; end
                2: begin wlen = 6'd32; thr = 16'd0; end
                3: begin wlen = 6'd63; thr = 16'd1; end
                4: begin wlen = 6'd8; thr = 16'd300; end
                5: begin wlen = 6'd1; thr = 16'hffff; end
                6: begin wlen = 6'($urandom_range(1, 32)); thr = raw[15:0]; end
                default: begin wlen = 6'd0; thr = 16'($urandom_range(0, 2000)); end
            endcase
            apply_setting(wlen, thr);
            idle_on = (p != 2);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                drift_x = int'(clamp_sample(drift_x + $urandom_range(0, 400) - 200));
                drift_y = int'(clamp_sample(drift_y + $urandom_range(0, 400) - 200));
                push_pair(int'(pick_sample(drift_x)), int'(pick_sample(drift_y)));
            end
            drain();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (expected_avgs.size() != 0)
        begin
            $error("%0d expected items never arrived", expected_avgs.size());
            errors++;
        end
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
src/wad_pkg.sv
src/wad_div.sv
src/wad_datapath.sv
src/wad_ctrl.sv
src/windowed_average_deadband.sv
tb/windowed_average_deadband_tb.sv
